// File: rtl/afrc_pkg.sv
// Package with shared types, constants and the CRC byte update for the frame receiver.
`default_nettype none

package afrc_pkg;

  localparam int unsigned TimeoutWidth       = 3;
  localparam int unsigned TimeoutTicksDefault = 5;

  localparam logic [7:0]  HeaderByte      = 8'hAA;
  localparam logic [7:0]  BroadcastAddr   = 8'hFF;
  localparam logic [7:0]  OwnAddrReset    = 8'd254;
  localparam logic [15:0] CrcPolyReset    = 16'h1021;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_OWN_ADDRESS    = 1'b0,
    CFG_CRC_POLYNOMIAL = 1'b1
  } cfg_index_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_CRC_ERROR  = 2'd2,
    ST_FRAME_GOOD = 2'd3
  } status_t;

  // Receive phases; unused codes behave as header hunting.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_DEST    = 4'd1,
    PH_SENDER  = 4'd2,
    PH_STAMP   = 4'd3,
    PH_COMMAND = 4'd4,
    PH_SIZE    = 4'd5,
    PH_DATA    = 4'd6,
    PH_CRC_LO  = 4'd7,
    PH_CRC_HI  = 4'd8
  } phase_t;

  // One byte through an MSB-first CRC16 with a programmable polynomial.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/addressed_frame_receiver_crc16_core.sv
// Addressed frame receiver: header hunt, address filter, on-the-fly CRC16 check.
// The result of an accepted input transaction appears on the output in the next cycle.
// Throughput: one transaction per cycle while the result channel is not stalled; the byte-wide
// CRC update and the phase decode sit between the frame state registers and the output register.
// Reset: rst_n is synchronous and active low; it returns the receiver to header
// hunting, clears the frame registers and loads the configuration reset values.
`default_nettype none

module addressed_frame_receiver_crc16_core
  import afrc_pkg::*;
#(
  parameter int unsigned TIMEOUT_TICKS = TimeoutTicksDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] action (0 byte, 1 timeout tick)

  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [9:2] payload_byte, [17:10] payload_index,
  // [25:18] sender_address, [33:26] time_stamp, [41:34] command_code,
  // [49:42] payload_size, [55:50] zero
  output logic [55:0]      out_tdata,
  output logic [0:0]       out_tuser,  // [0] payload_valid

  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [TimeoutWidth-1:0] TimeoutLoad = TimeoutWidth'(TIMEOUT_TICKS);

  // Configuration registers.
  logic [7:0]  own_address_r;
  logic [15:0] crc_poly_r;

  // Frame state.
  phase_t                  phase_r, phase_nxt;
  logic [15:0]             crc_r, crc_nxt;
  logic [7:0]              sender_r, sender_nxt;
  logic [7:0]              stamp_r, stamp_nxt;
  logic [7:0]              command_r, command_nxt;
  logic [7:0]              size_r, size_nxt;
  logic [7:0]              count_r, count_nxt;
  logic [7:0]              crc_lo_r, crc_lo_nxt;
  logic [TimeoutWidth-1:0] timeout_r, timeout_nxt;

  // Output register.
  logic        out_tvalid_r;
  logic [55:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;

  // Per-transaction decode.
  logic        in_fire;
  logic        action;
  logic [7:0]  rx_byte;
  logic [15:0] crc_seed;
  logic [15:0] crc_fed;
  logic [7:0]  count_inc;
  status_t     status;
  logic        pvalid;
  logic [7:0]  pbyte;
  logic [7:0]  pindex;

  // The output register takes a new result whenever it is empty or being drained,
  // so the input side stalls only while a result waits and the receiver holds it off.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign action    = in_tuser[0];
  assign rx_byte   = in_tdata;

  // The destination byte restarts the CRC from zero; later bytes continue it.
  assign crc_seed  = (phase_r == PH_DEST) ? 16'h0000 : crc_r;
  assign crc_fed   = crc16_feed(crc_seed, rx_byte, crc_poly_r);
  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    sender_nxt  = sender_r;
    stamp_nxt   = stamp_r;
    command_nxt = command_r;
    size_nxt    = size_r;
    count_nxt   = count_r;
    crc_lo_nxt  = crc_lo_r;
    timeout_nxt = timeout_r;
    status      = ST_NONE;
    pvalid      = 1'b0;
    pbyte       = 8'h00;
    pindex      = 8'h00;

    if (action) begin
      // A timeout tick runs the receive timer down and, when it expires, returns to header hunting.
      if (timeout_r != '0) begin
        timeout_nxt = timeout_r - TimeoutWidth'(1);
        if (timeout_r == TimeoutWidth'(1)) begin
          phase_nxt = PH_HUNT;
        end
      end
    end else begin
      timeout_nxt = TimeoutLoad;
      unique case (phase_r)
        PH_DEST: begin
          if (rx_byte == own_address_r || rx_byte == BroadcastAddr) begin
            crc_nxt   = crc_fed;
            phase_nxt = PH_SENDER;
          end else begin
            // Not for this node: quietly go back to hunting.
            phase_nxt = PH_HUNT;
          end
        end
        PH_SENDER: begin
          sender_nxt = rx_byte;
          crc_nxt    = crc_fed;
          phase_nxt  = PH_STAMP;
        end
        PH_STAMP: begin
          stamp_nxt = rx_byte;
          crc_nxt   = crc_fed;
          phase_nxt = PH_COMMAND;
        end
        PH_COMMAND: begin
          command_nxt = rx_byte;
          crc_nxt     = crc_fed;
          phase_nxt   = PH_SIZE;
        end
        PH_SIZE: begin
          size_nxt  = rx_byte;
          count_nxt = 8'h00;
          crc_nxt   = crc_fed;
          // An empty payload goes straight to the CRC bytes.
          phase_nxt = (rx_byte != 8'h00) ? PH_DATA : PH_CRC_LO;
        end
        PH_DATA: begin
          pvalid    = 1'b1;
          pbyte     = rx_byte;
          pindex    = count_r;
          crc_nxt   = crc_fed;
          count_nxt = count_inc;
          if (count_inc == size_r) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = rx_byte;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          // The CRC travels low byte first.
          status    = ({rx_byte, crc_lo_r} == crc_r) ? ST_FRAME_GOOD : ST_CRC_ERROR;
          phase_nxt = PH_HUNT;
        end
        default: begin
          // Header hunting, and any phase code that has no meaning.
          if (rx_byte == HeaderByte) begin
            phase_nxt = PH_DEST;
          end else begin
            phase_nxt = PH_HUNT;
            status    = ST_BAD_HEADER;
          end
        end
      endcase
    end

    // The frame fields are reported as they stand after this transaction.
    out_tdata_nxt = {6'b000000, size_nxt, command_nxt, stamp_nxt, sender_nxt,
                     pindex, pbyte, status};
    out_tuser_nxt = pvalid;
  end

  // Configuration writes; an address of zero or broadcast is replaced by the default.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= OwnAddrReset;
      crc_poly_r    <= CrcPolyReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_OWN_ADDRESS: begin
          if (cfg_wdata[7:0] == 8'h00 || cfg_wdata[7:0] == BroadcastAddr) begin
            own_address_r <= OwnAddrReset;
          end else begin
            own_address_r <= cfg_wdata[7:0];
          end
        end
        CFG_CRC_POLYNOMIAL: begin
          crc_poly_r <= cfg_wdata;
        end
        default: begin
          crc_poly_r <= crc_poly_r;
        end
      endcase
    end
  end

  // Frame state advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      crc_r     <= 16'h0000;
      sender_r  <= 8'h00;
      stamp_r   <= 8'h00;
      command_r <= 8'h00;
      size_r    <= 8'h00;
      count_r   <= 8'h00;
      crc_lo_r  <= 8'h00;
      timeout_r <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      sender_r  <= sender_nxt;
      stamp_r   <= stamp_nxt;
      command_r <= command_nxt;
      size_r    <= size_nxt;
      count_r   <= count_nxt;
      crc_lo_r  <= crc_lo_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  // Output register: valid is control, the payload loads on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

`ifndef SYNTH
  // A payload byte never carries a verdict.
  a_payload_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |-> (out_tdata_r[1:0] == ST_NONE))
    else $error("payload transaction carries a status code");

  // The receive timer never holds more than its load value.
  a_timeout_bound: assert property (@(posedge clk) disable iff (!rst_n)
    timeout_r <= TimeoutLoad)
    else $error("receive timer above its load value");

  // The second CRC byte always ends the frame.
  a_crc_hi_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !action && phase_r == PH_CRC_HI) |=> (phase_r == PH_HUNT))
    else $error("frame did not end after the second CRC byte");

  // Reset leaves the receiver hunting with no result pending.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (phase_r == PH_HUNT && !out_tvalid_r))
    else $error("receiver not idle after reset");
`endif

endmodule

`default_nettype wire
